// File: rtl/core/dmbq_pkg.sv
package dmbq_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 256;
	localparam int unsigned MAX_HEIGHT_DEF = 256;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_POINT = 2'd1,
		OP_CELL  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_CPU      = 3'd2,
		REG_WIDTH    = 3'd3,
		REG_HEIGHT   = 3'd4,
		REG_MAXDIST  = 3'd5
	} reg_idx_t;

	localparam logic [31:0] CPU_RESET     = 32'd655360;
	localparam logic [8:0]  GRID_RESET    = 9'd256;
	localparam logic [15:0] MAXDIST_RESET = 16'd1280;
	localparam logic [31:0] HALF_CELL     = 32'h8000_0000;
	localparam logic [16:0] ONE_Q16       = 17'h1_0000;

	// Round a magnitude by 32 bits to 16-bit signed, ties away from zero, saturating.
	function automatic logic [15:0] round_sat16(input logic neg, input logic [63:0] mag);
		logic [32:0] r;
		begin
			r = {1'b0, mag[63:32]} + {32'd0, mag[31]};
			if (neg) begin
				if (r > 33'd32768) r = 33'd32768;
				round_sat16 = 16'(-r);
			end else begin
				if (r > 33'd32767) r = 33'd32767;
				round_sat16 = r[15:0];
			end
		end
	endfunction

	// Round a magnitude by 24 bits to 32-bit signed, ties away from zero, saturating.
	function automatic logic [31:0] round_sat32(input logic neg, input logic [71:0] mag);
		logic [48:0] r;
		begin
			r = {1'b0, mag[71:24]} + {48'd0, mag[23]};
			if (neg) begin
				if (r > 49'h0_8000_0000) r = 49'h0_8000_0000;
				round_sat32 = 32'(-r);
			end else begin
				if (r > 49'h0_7FFF_FFFF) r = 49'h0_7FFF_FFFF;
				round_sat32 = r[31:0];
			end
		end
	endfunction

endpackage

// File: rtl/core/dmbq_map.sv
// Four interleaved distance banks, selected by the low bit of x and of y, so that
// the four corners of a 2x2 window are read together. Reads are registered.
module dmbq_map #(
	parameter int unsigned MAX_WIDTH  = dmbq_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = dmbq_pkg::MAX_HEIGHT_DEF,
	localparam int unsigned XW = $clog2(MAX_WIDTH),
	localparam int unsigned YW = $clog2(MAX_HEIGHT)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [XW-1:0]        wr_x,
	input  logic [YW-1:0]        wr_y,
	input  logic [15:0]          wr_data,
	input  logic                 rd_en,
	input  logic [XW-1:0]        rd_x,
	input  logic [YW-1:0]        rd_y,
	output logic [3:0][15:0]     rd_data
);
	localparam int unsigned HX = (MAX_WIDTH + 1) / 2;
	localparam int unsigned HY = (MAX_HEIGHT + 1) / 2;
	localparam int unsigned HXW = (HX > 1) ? $clog2(HX) : 1;
	localparam int unsigned HYW = (HY > 1) ? $clog2(HY) : 1;
	localparam int unsigned DEPTH = HX * HY;
	localparam int unsigned AW = $clog2(DEPTH);

	logic [15:0] bank0 [DEPTH];
	logic [15:0] bank1 [DEPTH];
	logic [15:0] bank2 [DEPTH];
	logic [15:0] bank3 [DEPTH];

	logic [XW:0] x1;
	logic [YW:0] y1;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra [4];
	logic [1:0] wb;

	function automatic logic [AW-1:0] addr(input logic [XW:0] x, input logic [YW:0] y);
		logic [HXW-1:0] hx;
		logic [HYW-1:0] hy;
		begin
			hx = HXW'(x >> 1);
			hy = HYW'(y >> 1);
			addr = AW'(32'(hy) * HX + 32'(hx));
		end
	endfunction

	always_comb begin
		x1 = {1'b0, rd_x} + 1'b1;
		y1 = {1'b0, rd_y} + 1'b1;
		wa = addr({1'b0, wr_x}, {1'b0, wr_y});
		wb = {wr_y[0], wr_x[0]};
		// Bank b holds cells with x parity b[0] and y parity b[1].
		for (int b = 0; b < 4; b++) begin
			ra[b] = addr((rd_x[0] == b[0]) ? {1'b0, rd_x} : x1,
				(rd_y[0] == b[1]) ? {1'b0, rd_y} : y1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wb == 2'd0) bank0[wa] <= wr_data;
		if (wr_en && wb == 2'd1) bank1[wa] <= wr_data;
		if (wr_en && wb == 2'd2) bank2[wa] <= wr_data;
		if (wr_en && wb == 2'd3) bank3[wa] <= wr_data;
		if (rd_en) begin
			rd_data[0] <= bank0[ra[0]];
			rd_data[1] <= bank1[ra[1]];
			rd_data[2] <= bank2[ra[2]];
			rd_data[3] <= bank3[ra[3]];
		end
	end
endmodule

// File: rtl/core/distance_map_bilinear_query_top.sv
// Distance map with bilinear point query.
// Throughput: one request per cycle unless the output stalls; the four-bank map
// serves a whole 2x2 window from a single read port each cycle, and a write
// finishes before any later read.
// Reset clears the pipeline valids and the registers to their defaults; the map
// is not cleared and reading an unwritten cell gives an unspecified value.
module distance_map_bilinear_query_top #(
	parameter int unsigned MAX_WIDTH  = dmbq_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = dmbq_pkg::MAX_HEIGHT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[1:0], cell_x[17:2], cell_y[33:18], cell_value[49:34],
	// point_x[81:50], point_y[113:82], safe_limit[129:114], zero fill
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// distance[15:0], gradient_x[47:16], gradient_y[79:48], in_bounds[80],
	// below_safe[81], zero fill
	output logic [87:0]  m_tdata
);
	localparam int unsigned XW = $clog2(MAX_WIDTH);
	localparam int unsigned YW = $clog2(MAX_HEIGHT);
	localparam int unsigned NSTG = 7;

	// Registers.
	logic signed [31:0] origin_x_q, origin_y_q;
	logic [31:0] cpu_q;
	logic [8:0]  width_q, height_q;
	logic [15:0] maxd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			cpu_q      <= dmbq_pkg::CPU_RESET;
			width_q    <= dmbq_pkg::GRID_RESET;
			height_q   <= dmbq_pkg::GRID_RESET;
			maxd_q     <= dmbq_pkg::MAXDIST_RESET;
		end else if (cfg_we) begin
			unique case (dmbq_pkg::reg_idx_t'(cfg_index))
				dmbq_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				dmbq_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
				dmbq_pkg::REG_CPU:      cpu_q      <= cfg_data;
				dmbq_pkg::REG_WIDTH:    width_q    <= cfg_data[8:0];
				dmbq_pkg::REG_HEIGHT:   height_q   <= cfg_data[8:0];
				dmbq_pkg::REG_MAXDIST:  maxd_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Effective grid size, clamped to the map size (13 bits covers 4096).
	logic [12:0] effw, effh;
	always_comb begin
		effw = (13'(width_q) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_q);
		effh = (13'(height_q) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_q);
	end

	// Skid-free flow: the whole pipeline advances when the output slot is free.
	logic adv;
	logic [NSTG-1:0] v_q;
	logic out_v_q;
	assign adv      = !out_v_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_v_q;

	logic acc;
	assign acc = s_tvalid && s_tready;

	// Input fields.
	logic [1:0]          in_op;
	logic signed [15:0]  in_cx, in_cy, in_cval, in_safe;
	logic signed [31:0]  in_px, in_py;
	assign in_op   = s_tdata[1:0];
	assign in_cx   = s_tdata[17:2];
	assign in_cy   = s_tdata[33:18];
	assign in_cval = s_tdata[49:34];
	assign in_px   = s_tdata[81:50];
	assign in_py   = s_tdata[113:82];
	assign in_safe = s_tdata[129:114];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_q     <= {v_q[NSTG-2:0], acc};
			out_v_q <= v_q[NSTG-1];
		end
	end

	// Stage 1: differences to the grid origin, cell bounds test.
	logic [1:0]         op_s1;
	logic signed [15:0] cx_s1, cy_s1, cval_s1, safe_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic               cin_s1;
	// Stage 2: products with cells_per_unit; cell writes happen here.
	logic [1:0]         op_s2;
	logic [15:0]        cval_s2, safe_s2;
	logic [XW-1:0]      cxa_s2;
	logic [YW-1:0]      cya_s2;
	logic               cin_s2, neg_s2;
	logic [63:0]        px_s2, py_s2;
	// Stage 3: floor cell, weights, window test, map read issue.
	logic [1:0]         op_s3;
	logic [15:0]        cval_s3, safe_s3;
	logic               inb_s3, xodd_s3, yodd_s3;
	logic [15:0]        wx_s3, wy_s3;
	// Stage 4: map data available.
	logic [1:0]         op_s4;
	logic [15:0]        cval_s4, safe_s4, wx_s4, wy_s4;
	logic               inb_s4;
	logic signed [15:0] d00_s4, d10_s4, d01_s4, d11_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= in_op;
			cx_s1   <= in_cx;
			cy_s1   <= in_cy;
			cval_s1 <= in_cval;
			safe_s1 <= in_safe;
			dx_s1   <= 33'(in_px) - 33'(origin_x_q);
			dy_s1   <= 33'(in_py) - 33'(origin_y_q);
			cin_s1  <= !in_cx[15] && !in_cy[15] && ({1'b0, in_cx[14:0]} < 16'(effw))
				&& ({1'b0, in_cy[14:0]} < 16'(effh));
		end
	end

	logic mul_neg;
	assign mul_neg = dx_s1[32] || dy_s1[32];

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			cval_s2 <= cval_s1;
			safe_s2 <= safe_s1;
			cxa_s2  <= cx_s1[XW-1:0];
			cya_s2  <= cy_s1[YW-1:0];
			cin_s2  <= cin_s1;
			neg_s2  <= mul_neg;
			px_s2   <= 64'(dx_s1[31:0]) * 64'(cpu_q);
			py_s2   <= 64'(dy_s1[31:0]) * 64'(cpu_q);
		end
	end

	// Floor and weight after removing half a cell.
	logic [63:0] qx, qy;
	logic        okx, oky, win_ok;
	always_comb begin
		okx = px_s2 >= 64'(dmbq_pkg::HALF_CELL);
		oky = py_s2 >= 64'(dmbq_pkg::HALF_CELL);
		qx  = px_s2 - 64'(dmbq_pkg::HALF_CELL);
		qy  = py_s2 - 64'(dmbq_pkg::HALF_CELL);
		win_ok = !neg_s2 && okx && oky && (33'(qx[63:32]) + 33'd1 < 33'(effw))
			&& (33'(qy[63:32]) + 33'd1 < 33'(effh));
	end

	logic          map_we;
	logic [XW-1:0] rdx;
	logic [YW-1:0] rdy;
	logic [3:0][15:0] rdat;
	assign map_we = adv && v_q[1] && op_s2 == dmbq_pkg::OP_WRITE && cin_s2;
	assign rdx = (op_s2 == dmbq_pkg::OP_POINT) ? qx[32 +: XW] : cxa_s2;
	assign rdy = (op_s2 == dmbq_pkg::OP_POINT) ? qy[32 +: YW] : cya_s2;

	dmbq_map #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_map (
		.clk     (clk),
		.wr_en   (map_we),
		.wr_x    (cxa_s2),
		.wr_y    (cya_s2),
		.wr_data (cval_s2),
		.rd_en   (adv),
		.rd_x    (rdx),
		.rd_y    (rdy),
		.rd_data (rdat)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3   <= op_s2;
			cval_s3 <= cval_s2;
			safe_s3 <= safe_s2;
			inb_s3  <= (op_s2 == dmbq_pkg::OP_POINT) ? win_ok : cin_s2;
			xodd_s3 <= rdx[0];
			yodd_s3 <= rdy[0];
			wx_s3   <= qx[31:16];
			wy_s3   <= qy[31:16];
		end
	end

	// Bank data registers at the same edge as stage 3, so it pairs with stage 3.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s4   <= op_s3;
			cval_s4 <= cval_s3;
			safe_s4 <= safe_s3;
			wx_s4   <= wx_s3;
			wy_s4   <= wy_s3;
			inb_s4  <= inb_s3;
			d00_s4  <= rdat[{yodd_s3, xodd_s3}];
			d10_s4  <= rdat[{yodd_s3, ~xodd_s3}];
			d01_s4  <= rdat[{~yodd_s3, xodd_s3}];
			d11_s4  <= rdat[{~yodd_s3, ~xodd_s3}];
		end
	end

	// Stage 5: row interpolation, Q8.24 values.
	logic [1:0]         op_s5;
	logic [15:0]        cval_s5, safe_s5, wy_s5;
	logic               inb_s5;
	logic signed [15:0] d00_s5;
	logic signed [40:0] r0_s5, r1_s5;
	logic signed [17:0] ex0_s5, ex1_s5;
	logic signed [17:0] ax4, bx4;
	assign ax4 = 18'(wx_s4);
	assign bx4 = 18'(dmbq_pkg::ONE_Q16) - 18'(wx_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s5   <= op_s4;
			cval_s5 <= cval_s4;
			safe_s5 <= safe_s4;
			wy_s5   <= wy_s4;
			inb_s5  <= inb_s4;
			d00_s5  <= d00_s4;
			r0_s5   <= 41'(bx4 * 34'(d00_s4)) + 41'(ax4 * 34'(d10_s4));
			r1_s5   <= 41'(bx4 * 34'(d01_s4)) + 41'(ax4 * 34'(d11_s4));
			ex0_s5  <= 18'(d10_s4) - 18'(d00_s4);
			ex1_s5  <= 18'(d11_s4) - 18'(d01_s4);
		end
	end

	// Stage 6: column interpolation and the x and y slopes, Q8.40 / Q8.24.
	logic [1:0]         op_s6;
	logic [15:0]        cval_s6, safe_s6;
	logic               inb_s6;
	logic signed [15:0] d00_s6;
	logic signed [58:0] dd_s6;
	logic signed [41:0] sx_s6, sy_s6;
	logic signed [17:0] ay5, by5;
	assign ay5 = 18'(wy_s5);
	assign by5 = 18'(dmbq_pkg::ONE_Q16) - 18'(wy_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s6   <= op_s5;
			cval_s6 <= cval_s5;
			safe_s6 <= safe_s5;
			inb_s6  <= inb_s5;
			d00_s6  <= d00_s5;
			dd_s6   <= 59'(by5 * 59'(r0_s5)) + 59'(ay5 * 59'(r1_s5));
			sx_s6   <= 42'(by5 * 36'(ex0_s5)) + 42'(ay5 * 36'(ex1_s5));
			sy_s6   <= 42'(r1_s5) - 42'(r0_s5);
		end
	end

	// Stage 7: distance rounded, slopes scaled per world unit (magnitudes, sign kept aside).
	logic [1:0]         op_s7;
	logic [15:0]        cval_s7, safe_s7;
	logic               inb_s7;
	logic signed [15:0] d00_s7;
	logic [15:0]        dist_s7;
	logic               gxn_s7, gyn_s7;
	logic [71:0]        gxm_s7, gym_s7;
	logic [41:0]        mx6, my6;
	logic [58:0]        md6;
	assign mx6 = sx_s6[41] ? 42'(-sx_s6) : 42'(sx_s6);
	assign my6 = sy_s6[41] ? 42'(-sy_s6) : 42'(sy_s6);
	assign md6 = dd_s6[58] ? 59'(-dd_s6) : 59'(dd_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s7   <= op_s6;
			cval_s7 <= cval_s6;
			safe_s7 <= safe_s6;
			inb_s7  <= inb_s6;
			d00_s7  <= d00_s6;
			dist_s7 <= dmbq_pkg::round_sat16(dd_s6[58], 64'(md6));
			gxn_s7  <= sx_s6[41];
			gyn_s7  <= sy_s6[41];
			// Slope magnitudes stay below 2^32, so each product is 32 x 32.
			gxm_s7  <= 72'(mx6[31:0]) * 72'(cpu_q);
			gym_s7  <= 72'(my6[31:0]) * 72'(cpu_q);
		end
	end

	// Output assembly.
	logic [15:0] o_dist;
	logic [31:0] o_gx, o_gy;
	logic        o_inb, o_below;
	always_comb begin
		o_dist  = '0;
		o_gx    = '0;
		o_gy    = '0;
		o_inb   = 1'b0;
		o_below = 1'b0;
		unique case (dmbq_pkg::op_t'(op_s7))
			dmbq_pkg::OP_WRITE: begin
				o_dist = cval_s7;
				o_inb  = inb_s7;
			end
			dmbq_pkg::OP_POINT: begin
				o_inb = inb_s7;
				if (inb_s7) begin
					o_dist = dist_s7;
					o_gx   = dmbq_pkg::round_sat32(gxn_s7, gxm_s7);
					o_gy   = dmbq_pkg::round_sat32(gyn_s7, gym_s7);
				end else begin
					o_dist = maxd_q;
				end
			end
			dmbq_pkg::OP_CELL: begin
				o_inb   = inb_s7;
				o_dist  = inb_s7 ? d00_s7 : maxd_q;
				o_below = $signed(o_dist) < $signed(safe_s7);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) m_tdata <= {6'd0, o_below, o_inb, o_gy, o_gx, o_dist};
	end

	// Assertions.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
	a_write_only_inside: assert property (@(posedge clk) disable iff (!arst_n)
		map_we |-> cin_s2 && op_s2 == dmbq_pkg::OP_WRITE)
		else $error("map write outside grid");
	a_grad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[80] |-> m_tdata[79:16] == '0)
		else $error("gradient on out-of-bounds result");
endmodule
